@@ rtl/galc_pkg.sv @@
// Shared types, codes and the display band table for the gas alarm level controller.
// Used by every module under rtl/; depends on nothing else.
`timescale 1ns / 1ps

package galc_pkg;

    // Field widths
    localparam int unsigned LEN_W   = 5;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PPM_W   = 16;
    localparam int unsigned BAND_W  = 4;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_A_W = 2;
    localparam int unsigned S_DATA_W = 32;
    localparam int unsigned M_DATA_W = 32;

    // Default depth of the queue between front and back
    localparam int unsigned GALC_QUEUE_DEPTH = 2;

    // Reply framing
    localparam logic [LEN_W-1:0]  VALID_REPLY_LEN = LEN_W'(7);
    localparam logic [BYTE_W-1:0] REPLY_LEAD      = BYTE_W'(8'h02);

    // Register reset values
    localparam logic [CFG_W-1:0] WARN_RESET   = CFG_W'(250);
    localparam logic [CFG_W-1:0] DANGER_RESET = CFG_W'(400);
    localparam logic [CNT_W-1:0] DELAY_RESET  = CNT_W'(20);

    // Register indexes
    typedef enum logic [CFG_A_W-1:0] {
        CFG_WARN_THRESHOLD   = 2'd0,
        CFG_DANGER_THRESHOLD = 2'd1,
        CFG_DELAY_COUNT      = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        LVL_SAFE   = 2'd0,
        LVL_WARN   = 2'd1,
        LVL_DANGER = 2'd2
    } t_level;

    typedef enum logic [2:0] {
        SND_NONE      = 3'd0,
        SND_SILENCE   = 3'd1,
        SND_SPEAK     = 3'd2,
        SND_BEEP      = 3'd3,
        SND_DBL_SPEAK = 3'd4,
        SND_DBL       = 3'd5
    } t_sound;

    typedef enum logic [1:0] {
        RLY_NONE  = 2'd0,
        RLY_OPEN  = 2'd1,
        RLY_CLOSE = 2'd2
    } t_relay;

    // Configuration as seen by front and back
    typedef struct packed {
        logic [PPM_W-1:0] warn_threshold;
        logic [PPM_W-1:0] danger_threshold;
        logic [CNT_W-1:0] delay_count;
    } t_galc_cfg;

    // One classified poll, handed from front to back
    typedef struct packed {
        logic [PPM_W-1:0]  ppm;
        logic [BAND_W-1:0] band;
        logic              power;
        logic              below_warn;
        logic              in_warn;
        logic              at_danger;
    } t_poll_class;

    // One result word
    typedef struct packed {
        t_level            level;
        t_relay            relay;
        t_sound            sound;
        logic [BAND_W-1:0] band;
        logic [PPM_W-1:0]  ppm;
    } t_galc_result;

    // Display band code from ppm ranges
    function automatic logic [BAND_W-1:0] band_of(input logic [PPM_W-1:0] p);
        logic [BAND_W-1:0] b;
        if (p == PPM_W'(0))        b = BAND_W'(0);
        else if (p <= PPM_W'(110)) b = BAND_W'(1);
        else if (p <= PPM_W'(180)) b = BAND_W'(0);
        else if (p <= PPM_W'(249)) b = BAND_W'(2);
        else if (p <= PPM_W'(300)) b = BAND_W'(3);
        else if (p <= PPM_W'(350)) b = BAND_W'(4);
        else if (p <= PPM_W'(399)) b = BAND_W'(5);
        else if (p <= PPM_W'(450)) b = BAND_W'(6);
        else if (p <= PPM_W'(500)) b = BAND_W'(7);
        else                       b = BAND_W'(8);
        return b;
    endfunction

endpackage

@@ rtl/galc_front.sv @@
// Front part: accepts poll words, holds ppm and display band, classifies ppm.
// Depends on galc_pkg.
`timescale 1ns / 1ps

module galc_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  galc_pkg::t_galc_cfg      i_cfg,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [galc_pkg::LEN_W-1:0]  i_reply_length,
    input  logic [galc_pkg::BYTE_W-1:0] i_reply_lead_byte,
    input  logic [galc_pkg::BYTE_W-1:0] i_ppm_high_byte,
    input  logic [galc_pkg::BYTE_W-1:0] i_ppm_low_byte,
    input  logic                     i_power_on,
    output logic                     o_push,
    output galc_pkg::t_poll_class    o_class,
    input  logic                     i_queue_ready
);
    import galc_pkg::*;

    logic [PPM_W-1:0]  r_ppm, n_ppm;
    logic [BAND_W-1:0] r_band, n_band;
    logic              w_len_ok;
    logic              w_accept;

    assign o_ready  = i_queue_ready;
    assign w_accept = i_valid && i_queue_ready;
    assign o_push   = w_accept;

    // Refresh ppm on a good reply, band on any full-length reply
    always_comb begin
        w_len_ok = (i_reply_length == VALID_REPLY_LEN);
        n_ppm    = r_ppm;
        n_band   = r_band;
        if (w_len_ok) begin
            if (i_reply_lead_byte == REPLY_LEAD) begin
                n_ppm = {i_ppm_high_byte, i_ppm_low_byte};
            end
            n_band = band_of(n_ppm);
        end
    end

    // Classify the held ppm against the thresholds
    always_comb begin
        o_class.ppm        = n_ppm;
        o_class.band       = n_band;
        o_class.power      = i_power_on;
        o_class.below_warn = (n_ppm < i_cfg.warn_threshold);
        o_class.in_warn    = (n_ppm >= i_cfg.warn_threshold)
                             && (n_ppm < i_cfg.danger_threshold);
        o_class.at_danger  = (n_ppm >= i_cfg.danger_threshold);
    end

    // Hold ppm and band across polls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppm  <= '0;
            r_band <= '0;
        end else if (w_accept) begin
            r_ppm  <= n_ppm;
            r_band <= n_band;
        end
    end

endmodule

@@ rtl/galc_queue.sv @@
// Short queue of classified polls between front and back.
// Depends on galc_pkg.
`timescale 1ns / 1ps

module galc_queue #(
    parameter int unsigned DEPTH = galc_pkg::GALC_QUEUE_DEPTH  // 2 or more
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  galc_pkg::t_poll_class i_data,
    output logic                  o_ready,
    input  logic                  i_pop,
    output logic                  o_valid,
    output galc_pkg::t_poll_class o_data
);
    import galc_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

    t_poll_class       r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_QW-1:0] r_count, n_count;
    logic              w_push, w_pop;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_QW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_QW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/galc_back.sv @@
// Back part: alarm level machine, sound and relay commands, output register.
// Depends on galc_pkg.
`timescale 1ns / 1ps

module galc_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  galc_pkg::t_galc_cfg    i_cfg,
    input  logic                   i_valid,
    input  galc_pkg::t_poll_class  i_class,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output galc_pkg::t_galc_result o_result
);
    import galc_pkg::*;

    t_level           r_level, n_level;
    t_level           r_prev, n_prev;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid;
    t_galc_result     r_out;
    t_sound           w_sound;
    t_relay           w_relay;
    logic             w_pop;

    // Step-by-step conditions of the level machine
    logic             a_hit, b1, b2, b2_fire, b3, b4, c_hit;
    t_level           cl_a, pl_a, cl_b1;
    logic [CNT_W-1:0] cnt_a, cnt_b1;

    assign w_pop   = i_valid && (!r_out_valid || i_ready);
    assign o_pop   = w_pop;
    assign o_valid = r_out_valid;
    assign o_result = r_out;

    // Evaluate the safe, warning and danger checks in order
    always_comb begin
        a_hit   = i_class.below_warn && (r_level != LVL_SAFE);
        cl_a    = a_hit ? LVL_SAFE : r_level;
        pl_a    = a_hit ? LVL_SAFE : r_prev;
        cnt_a   = a_hit ? '0 : r_cnt;
        b1      = i_class.in_warn && (r_level == LVL_SAFE) && (r_prev == LVL_SAFE);
        cl_b1   = b1 ? LVL_WARN : r_level;
        cnt_b1  = b1 ? '0 : r_cnt;
        b2      = i_class.in_warn && (cl_b1 == LVL_WARN) && (r_prev == LVL_SAFE);
        b2_fire = b2 && (cnt_b1 >= i_cfg.delay_count);
        b3      = i_class.in_warn && (r_level == LVL_DANGER) && (r_prev == LVL_DANGER);
        b4      = i_class.in_warn && (r_level == LVL_WARN) && (r_prev == LVL_DANGER);
        c_hit   = i_class.at_danger && (cl_a != LVL_DANGER);
    end

    // Next level, previous level and counter
    always_comb begin
        n_level = r_level;
        n_prev  = r_prev;
        n_cnt   = r_cnt;
        if (!i_class.power) begin
            n_level = LVL_SAFE;
            n_prev  = LVL_SAFE;
            n_cnt   = '0;
        end else if (i_class.in_warn) begin
            n_level = (b1 || b3) ? LVL_WARN : r_level;
            n_prev  = (b2_fire || b3 || b4) ? LVL_WARN : r_prev;
            if (b2) begin
                n_cnt = b2_fire ? '0 : cnt_b1 + CNT_W'(1);
            end else begin
                n_cnt = cnt_b1;
            end
        end else begin
            n_level = cl_a;
            n_prev  = pl_a;
            n_cnt   = cnt_a;
            if (c_hit) begin
                n_level = LVL_DANGER;
                n_prev  = LVL_DANGER;
                n_cnt   = '0;
            end
        end
    end

    // Sound and relay commands: the last one issued wins
    always_comb begin
        w_sound = SND_NONE;
        w_relay = RLY_NONE;
        if (!i_class.power) begin
            w_sound = SND_SILENCE;
            w_relay = RLY_CLOSE;
        end else begin
            if (a_hit) begin
                w_sound = SND_SILENCE;
                w_relay = RLY_CLOSE;
            end
            if (b1) begin
                w_sound = SND_SPEAK;
                w_relay = RLY_OPEN;
            end
            if (b2_fire || b3) begin
                w_sound = SND_BEEP;
            end
            if (c_hit) begin
                w_sound = ((cl_a == LVL_SAFE) && (pl_a == LVL_SAFE)) ? SND_DBL_SPEAK
                                                                      : SND_DBL;
                w_relay = RLY_OPEN;
            end
        end
    end

    // Advance machine state on each word taken from the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= LVL_SAFE;
            r_prev      <= LVL_SAFE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_level     <= n_level;
                r_prev      <= n_prev;
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out.ppm   <= i_class.ppm;
            r_out.band  <= i_class.band;
            r_out.sound <= w_sound;
            r_out.relay <= w_relay;
            r_out.level <= n_level;
        end
    end

endmodule

@@ rtl/gas_alarm_level_controller.sv @@
// Top level of the gas alarm level controller: config registers, front, queue, back.
// Depends on galc_pkg, galc_front, galc_queue and galc_back.
`timescale 1ns / 1ps

// Takes one sensor poll word per cycle while the queue has room and returns one result
// word per poll, in order. A poll passes the front (ppm and band hold, threshold
// compare) in its accept cycle, is registered in a short queue, and the back's level
// machine turns it into a result word; the sustained rate is one poll per clock while
// the output side takes words. The output register lets a new poll be accepted while
// a finished result still waits. The user must write thresholds and the warning delay
// through the plain write port while the block is idle; the block does not enforce it.
module gas_alarm_level_controller #(
    parameter int unsigned QUEUE_DEPTH = galc_pkg::GALC_QUEUE_DEPTH  // 2 or more
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tdata: reply_length[4:0], reply_lead_byte[12:5], ppm_high_byte[20:13],
    //        ppm_low_byte[28:21], power_on[29], zero[31:30]
    input  logic [galc_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: concentration[15:0], display_band[19:16], sound_command[22:20],
    //        relay_action[24:23], alarm_level[26:25], zero[31:27]
    output logic [galc_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic                            i_cfg_we,
    input  logic [galc_pkg::CFG_A_W-1:0]    i_cfg_addr,
    input  logic [galc_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import galc_pkg::*;

    t_galc_cfg    r_cfg;
    logic         w_push, w_q_ready, w_q_valid, w_pop;
    t_poll_class  w_push_class, w_pop_class;
    t_galc_result w_result;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warn_threshold   <= WARN_RESET;
            r_cfg.danger_threshold <= DANGER_RESET;
            r_cfg.delay_count      <= DELAY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WARN_THRESHOLD:   r_cfg.warn_threshold   <= i_cfg_wdata;
                CFG_DANGER_THRESHOLD: r_cfg.danger_threshold <= i_cfg_wdata;
                CFG_DELAY_COUNT:      r_cfg.delay_count      <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    galc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_valid           (i_s_axis_tvalid),
        .o_ready           (o_s_axis_tready),
        .i_reply_length    (i_s_axis_tdata[4:0]),
        .i_reply_lead_byte (i_s_axis_tdata[12:5]),
        .i_ppm_high_byte   (i_s_axis_tdata[20:13]),
        .i_ppm_low_byte    (i_s_axis_tdata[28:21]),
        .i_power_on        (i_s_axis_tdata[29]),
        .o_push            (w_push),
        .o_class           (w_push_class),
        .i_queue_ready     (w_q_ready)
    );

    galc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_class),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_pop_class)
    );

    galc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_q_valid),
        .i_class  (w_pop_class),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (w_result)
    );

    // Pack the result word
    assign o_m_axis_tdata = {5'b0, w_result.level, w_result.relay, w_result.sound,
                             w_result.band, w_result.ppm};

endmodule

@@ test/gas_alarm_level_controller_test.sv @@
// Self-checking regression for the gas alarm level controller: directed and random polls.
// Depends on galc_pkg and gas_alarm_level_controller from rtl/; a scoreboard class predicts
// every result word and checks the output stream in order.
`timescale 1ns / 1ps

module gas_alarm_level_controller_test;
    import galc_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 200_000;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned PRESSURE_AT     = 500;
    localparam int unsigned PRESSURE_CYCLES = 64;
    localparam int unsigned SWAP_IDLE_AT    = 700;
    localparam int unsigned NO_IDLE_AT      = 1400;
    localparam int unsigned MAX_PRINTED     = 40;

    // One poll word, lowest field last: matches the input tdata layout
    typedef struct packed {
        logic              power;
        logic [BYTE_W-1:0] ppm_low;
        logic [BYTE_W-1:0] ppm_high;
        logic [BYTE_W-1:0] lead;
        logic [LEN_W-1:0]  length;
    } t_poll_word;

    typedef enum int {
        REGION_BELOW,
        REGION_WARN,
        REGION_DANGER
    } t_region;

    // Alarm level predictor with its own copy of registers and state
    class alarm_scoreboard;
        logic [PPM_W-1:0]  warn_ppm;
        logic [PPM_W-1:0]  danger_ppm;
        logic [CNT_W-1:0]  beep_delay;
        logic [PPM_W-1:0]  ppm_held;
        logic [BAND_W-1:0] band_held;
        t_level            level_now;
        t_level            level_last;
        logic [CNT_W-1:0]  warn_polls;
        t_galc_result      expected_words[$];
        int unsigned       checked;
        int unsigned       mismatches;

        function new();
            warn_ppm   = WARN_RESET;
            danger_ppm = DANGER_RESET;
            beep_delay = DELAY_RESET;
            ppm_held   = '0;
            band_held  = '0;
            level_now  = LVL_SAFE;
            level_last = LVL_SAFE;
            warn_polls = '0;
            checked    = 0;
            mismatches = 0;
        endfunction

        function void set_register(t_cfg_index idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_WARN_THRESHOLD: begin
                    warn_ppm = val;
                end
                CFG_DANGER_THRESHOLD: begin
                    danger_ppm = val;
                end
                CFG_DELAY_COUNT: begin
                    beep_delay = val[CNT_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        // Display band: smallest range top at or above the ppm picks the code
        function logic [BAND_W-1:0] band_for(logic [PPM_W-1:0] ppm);
            int unsigned       tops[8];
            int unsigned       codes[8];
            logic [BAND_W-1:0] code;
            tops  = '{110, 180, 249, 300, 350, 399, 450, 500};
            codes = '{1, 0, 2, 3, 4, 5, 6, 7};
            code  = BAND_W'(8);
            for (int i = 7; i >= 0; i--) begin
                if (ppm <= tops[i]) code = BAND_W'(codes[i]);
            end
            if (ppm == '0) code = '0;
            return code;
        endfunction

        // Advance the level machine by one poll and queue the word it yields
        function void note_poll(t_poll_word w);
            t_galc_result     want;
            t_sound           snd;
            t_relay           rly;
            logic [CNT_W-1:0] was;
            snd = SND_NONE;
            rly = RLY_NONE;
            if (w.length == VALID_REPLY_LEN) begin
                if (w.lead == REPLY_LEAD) ppm_held = {w.ppm_high, w.ppm_low};
                band_held = band_for(ppm_held);
            end
            if (!w.power) begin
                warn_polls = '0;
                level_now  = LVL_SAFE;
                level_last = LVL_SAFE;
                snd = SND_SILENCE;
                rly = RLY_CLOSE;
            end else begin
                // back to safe
                if (ppm_held < warn_ppm && level_now != LVL_SAFE) begin
                    warn_polls = '0;
                    level_now  = LVL_SAFE;
                    level_last = LVL_SAFE;
                    snd = SND_SILENCE;
                    rly = RLY_CLOSE;
                end
                // warning band
                if (ppm_held >= warn_ppm && ppm_held < danger_ppm) begin
                    if (level_now == LVL_SAFE && level_last == LVL_SAFE) begin
                        level_now  = LVL_WARN;
                        warn_polls = '0;
                        snd = SND_SPEAK;
                        rly = RLY_OPEN;
                    end
                    if (level_now == LVL_WARN && level_last == LVL_SAFE) begin
                        was = warn_polls;
                        warn_polls = was + 1'b1;
                        if (was >= beep_delay) begin
                            warn_polls = '0;
                            snd = SND_BEEP;
                            level_last = LVL_WARN;
                        end
                    end
                    if (level_now == LVL_DANGER && level_last == LVL_DANGER) begin
                        level_now  = LVL_WARN;
                        level_last = LVL_WARN;
                        snd = SND_BEEP;
                    end
                    if (level_now == LVL_WARN && level_last == LVL_DANGER) begin
                        level_last = LVL_WARN;
                    end
                end
                // danger latches
                if (ppm_held >= danger_ppm && level_now != LVL_DANGER) begin
                    warn_polls = '0;
                    if (level_now == LVL_SAFE && level_last == LVL_SAFE) snd = SND_DBL_SPEAK;
                    else snd = SND_DBL;
                    level_now  = LVL_DANGER;
                    level_last = LVL_DANGER;
                    rly = RLY_OPEN;
                end
            end
            want.ppm   = ppm_held;
            want.band  = band_held;
            want.sound = snd;
            want.relay = rly;
            want.level = level_now;
            expected_words.push_back(want);
        endfunction

        task report_mismatch(string what);
            if (mismatches < MAX_PRINTED) $display("[%0t] word %0d: %s", $time, checked, what);
            mismatches++;
        endtask

        // Compare one output word with the oldest expectation
        task check_result(logic [M_DATA_W-1:0] word);
            t_galc_result got;
            t_galc_result want;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("word %h with no poll waiting", word));
                return;
            end
            got  = word[$bits(t_galc_result)-1:0];
            want = expected_words.pop_front();
            if (word[M_DATA_W-1:$bits(t_galc_result)] !== '0)
                report_mismatch($sformatf("pad bits not zero in %h", word));
            if (got.ppm !== want.ppm)
                report_mismatch($sformatf("concentration %0d, want %0d", got.ppm, want.ppm));
            if (got.band !== want.band)
                report_mismatch($sformatf("band %0d, want %0d", got.band, want.band));
            if (got.sound !== want.sound)
                report_mismatch($sformatf("sound %0d, want %0d", got.sound, want.sound));
            if (got.relay !== want.relay)
                report_mismatch($sformatf("relay %0d, want %0d", got.relay, want.relay));
            if (got.level !== want.level)
                report_mismatch($sformatf("level %0d, want %0d", got.level, want.level));
            checked++;
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic [S_DATA_W-1:0]   i_s_axis_tdata;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [M_DATA_W-1:0]   o_m_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic                  i_cfg_we;
    logic [CFG_A_W-1:0]    i_cfg_addr;
    logic [CFG_W-1:0]      i_cfg_wdata;

    alarm_scoreboard sb;
    int unsigned     sent_count;
    int unsigned     setting_count;
    int unsigned     cycle_count;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;
    bit              pressure_done;

    gas_alarm_level_controller u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("gas_alarm_level_controller regression: fail");
            $finish;
        end
    end

    // Check every word taken from the output
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) sb.check_result(o_m_axis_tdata);
    end

    // Output side: random stalls, plus one long hold-off to fill the block
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!pressure_done && sent_count >= PRESSURE_AT) begin
                i_m_axis_tready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(negedge i_clk);
                pressure_done = 1'b1;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic t_poll_word clean_poll(logic [PPM_W-1:0] ppm);
        t_poll_word w;
        w.length   = VALID_REPLY_LEN;
        w.lead     = REPLY_LEAD;
        w.ppm_high = ppm[15:8];
        w.ppm_low  = ppm[7:0];
        w.power    = 1'b1;
        return w;
    endfunction

    function automatic t_poll_word noise_poll();
        t_poll_word       w;
        logic [PPM_W-1:0] ppm;
        ppm = ($urandom_range(1) != 0) ? PPM_W'($urandom_range(600)) : PPM_W'($urandom);
        w = clean_poll(ppm);
        w.length = LEN_W'($urandom_range(16));
        if ($urandom_range(1) != 0) w.lead = BYTE_W'($urandom);
        return w;
    endfunction

    // Pick a ppm inside a level region for the current thresholds, often near its ends
    function automatic logic [PPM_W-1:0] pick_ppm(t_region region);
        int unsigned lo_b;
        int unsigned hi_b;
        int unsigned near;
        int unsigned r;
        lo_b = 0;
        hi_b = 65535;
        case (region)
            REGION_BELOW: begin
                if (sb.warn_ppm != '0) hi_b = sb.warn_ppm - 1;
            end
            REGION_WARN: begin
                if (sb.danger_ppm > sb.warn_ppm) begin
                    lo_b = sb.warn_ppm;
                    hi_b = sb.danger_ppm - 1;
                end
            end
            default: begin
                lo_b = sb.danger_ppm;
            end
        endcase
        near = (hi_b - lo_b < 3) ? hi_b - lo_b : 3;
        r = $urandom_range(9);
        if (r < 3) return PPM_W'(lo_b + $urandom_range(near));
        if (r < 6) return PPM_W'(hi_b - $urandom_range(near));
        return PPM_W'($urandom_range(hi_b, lo_b));
    endfunction

    // Offer one poll word and hold it until taken
    task automatic send_poll(t_poll_word w);
        if (sent_count < SWAP_IDLE_AT) begin
            send_idle_pct = 30;
            recv_idle_pct = 78;
        end else if (sent_count < NO_IDLE_AT) begin
            send_idle_pct = 78;
            recv_idle_pct = 30;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        // idle each cycle with the chosen odds
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tdata  <= {2'b00, w};
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_poll(w);
        sent_count++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every expected word
    task automatic finish_phase();
        i_s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.expected_words.size() != 0);
    endtask

    // Write all three registers back to back while idle
    task automatic apply_setting(logic [CFG_W-1:0] warn, logic [CFG_W-1:0] danger,
                                 logic [CFG_W-1:0] delay_polls);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_WARN_THRESHOLD;
        i_cfg_wdata <= warn;
        @(negedge i_clk);
        i_cfg_addr  <= CFG_DANGER_THRESHOLD;
        i_cfg_wdata <= danger;
        @(negedge i_clk);
        i_cfg_addr  <= CFG_DELAY_COUNT;
        i_cfg_wdata <= delay_polls;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_register(CFG_WARN_THRESHOLD, warn);
        sb.set_register(CFG_DANGER_THRESHOLD, danger);
        sb.set_register(CFG_DELAY_COUNT, delay_polls);
        setting_count++;
    endtask

    // Band edges, level changes and the special replies under reset thresholds
    task automatic directed_polls();
        int unsigned marks[18];
        t_poll_word  w;
        marks = '{0, 110, 111, 180, 181, 249, 250, 300, 301, 350, 351, 399,
                  400, 450, 451, 500, 501, 65535};
        foreach (marks[i]) send_poll(clean_poll(PPM_W'(marks[i])));
        // bad lead byte on a full reply: ppm kept, band recomputed
        w = clean_poll(PPM_W'(0));
        w.lead = ~REPLY_LEAD;
        send_poll(w);
        // wrong lengths: ppm and band kept
        w = clean_poll(PPM_W'(0));
        w.length = LEN_W'(16);
        send_poll(w);
        w.length = LEN_W'(0);
        send_poll(w);
        // danger down to warning, down to safe, straight up to danger
        send_poll(clean_poll(PPM_W'(300)));
        send_poll(clean_poll(PPM_W'(100)));
        send_poll(clean_poll(PPM_W'(65535)));
        // power off still loads the reply
        w = clean_poll(PPM_W'(260));
        w.power = 1'b0;
        send_poll(w);
        w = clean_poll(PPM_W'(0));
        w.length = LEN_W'(6);
        send_poll(w);
    endtask

    // Runs of well-formed polls in one level region, mixed with noise and power loss
    task automatic run_random(int unsigned count, int unsigned max_run);
        int unsigned done_n;
        int unsigned run_len;
        int unsigned pick;
        t_region     region;
        t_poll_word  w;
        done_n = 0;
        while (done_n < count) begin
            pick = $urandom_range(99);
            region = t_region'($urandom_range(2));
            run_len = (pick < 20) ? $urandom_range(3, 1) : $urandom_range(max_run, 1);
            for (int i = 0; i < run_len && done_n < count; i++) begin
                if (pick < 8) begin
                    w = ($urandom_range(1) != 0) ? noise_poll() : clean_poll(pick_ppm(region));
                    w.power = 1'b0;
                end else if (pick < 20) begin
                    w = noise_poll();
                    w.power = ($urandom_range(7) != 0);
                end else if ($urandom_range(9) == 0) begin
                    w = noise_poll();
                    if (w.length == VALID_REPLY_LEN && w.lead == REPLY_LEAD) w.lead = ~REPLY_LEAD;
                end else begin
                    w = clean_poll(pick_ppm(region));
                end
                send_poll(w);
                done_n++;
            end
        end
    endtask

    initial begin
        sb = new();
        sent_count      = 0;
        setting_count   = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = CFG_WARN_THRESHOLD;
        i_cfg_wdata     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_polls();
        finish_phase();
        apply_setting(WARN_RESET, DANGER_RESET, CFG_W'(DELAY_RESET));
        run_random(400, 40);
        finish_phase();
        apply_setting(CFG_W'(0), CFG_W'(65535), CFG_W'(1));
        run_random(250, 8);
        finish_phase();
        apply_setting(CFG_W'(65535), CFG_W'(0), CFG_W'(254));
        run_random(200, 20);
        finish_phase();
        apply_setting(CFG_W'(300), CFG_W'(300), CFG_W'(3));
        run_random(250, 12);
        finish_phase();
        apply_setting(CFG_W'(500), CFG_W'(120), CFG_W'(5));
        run_random(200, 12);
        finish_phase();
        // long warning runs reach the largest beep delay
        apply_setting(CFG_W'(100), CFG_W'(1000), CFG_W'(254));
        run_random(400, 300);
        finish_phase();
        repeat (2) begin
            apply_setting(CFG_W'($urandom_range(600)), CFG_W'($urandom_range(800)),
                          CFG_W'($urandom_range(254, 1)));
            run_random(150, 40);
            finish_phase();
        end

        // catch stray words after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d polls under %0d threshold settings with stalls on both sides",
                 sent_count, setting_count);
        $display("%0d result words checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
            $display("gas_alarm_level_controller regression: pass");
        end else begin
            $display("gas_alarm_level_controller regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/galc_pkg.sv
rtl/galc_front.sv
rtl/galc_queue.sv
rtl/galc_back.sv
rtl/gas_alarm_level_controller.sv
test/gas_alarm_level_controller_test.sv
